>>> rtl/scf_pkg.sv
package scf_pkg;

    localparam int MOTOR_COUNT = 5;
    localparam int SLOT_COUNT  = 6;
    localparam int MOTOR_W     = 3;
    localparam int SLOT_W      = 3;
    localparam int BYTE_IDX_W  = 4;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_SPEED    = 2'd1;
    localparam logic [1:0] OP_POSITION = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_LAST_SPEED = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SYNC       = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_POSITION   = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_MAX        = SLOT_W'(SLOT_COUNT - 1);

    // Table entry that holds the position frame's motor.
    localparam logic [MOTOR_W-1:0] POS_MOTOR_IDX = MOTOR_W'(MOTOR_COUNT - 1);

    localparam logic [7:0] CMD_SPEED    = 8'hF6;
    localparam logic [7:0] CMD_POSITION = 8'hFD;
    localparam logic [7:0] BCAST_ADDR   = 8'h00;
    localparam logic [7:0] SYNC_MARK    = 8'hFF;
    localparam logic [7:0] SYNC_CMD     = 8'h66;
    localparam logic [7:0] FRAME_END    = 8'h6B;

    typedef struct packed {
        logic        direction;
        logic [15:0] speed;
        logic [7:0]  accel;
        logic [31:0] steps;
    } entry_t;

    typedef enum logic [2:0] {
        FR_SPEED    = 3'b001,
        FR_SYNC     = 3'b010,
        FR_POSITION = 3'b100
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t             kind;
        logic [BYTE_IDX_W-1:0]   index;
        logic [MOTOR_W-1:0]      motor_idx;
    } frame_ctl_t;

    function automatic logic [BYTE_IDX_W-1:0] frame_last_index(frame_kind_t kind);
        logic [BYTE_IDX_W-1:0] last;
        unique case (kind)
            FR_SPEED:    last = 4'd7;
            FR_SYNC:     last = 4'd3;
            FR_POSITION: last = 4'd12;
            default:     last = 4'd3;
        endcase
        return last;
    endfunction

endpackage

>>> rtl/scf_framer.sv
module scf_framer
    import scf_pkg::*;
(
    input  frame_ctl_t  ctl,
    input  entry_t      entry,
    output logic [7:0]  frame_byte,
    output logic        byte_last
);

    logic [7:0] speed_byte;
    logic [7:0] sync_byte;
    logic [7:0] pos_byte;

    always_comb
    begin
        unique case (ctl.index)
            4'd0:    speed_byte = 8'(ctl.motor_idx) + 8'd1;
            4'd1:    speed_byte = CMD_SPEED;
            4'd2:    speed_byte = {7'd0, entry.direction};
            4'd3:    speed_byte = entry.speed[15:8];
            4'd4:    speed_byte = entry.speed[7:0];
            4'd5:    speed_byte = 8'h00;
            4'd6:    speed_byte = 8'h01;
            default: speed_byte = FRAME_END;
        endcase
    end

    always_comb
    begin
        unique case (ctl.index)
            4'd0:    sync_byte = BCAST_ADDR;
            4'd1:    sync_byte = SYNC_MARK;
            4'd2:    sync_byte = SYNC_CMD;
            default: sync_byte = FRAME_END;
        endcase
    end

    always_comb
    begin
        unique case (ctl.index)
            4'd0:    pos_byte = 8'(POS_MOTOR_IDX) + 8'd1;
            4'd1:    pos_byte = CMD_POSITION;
            4'd2:    pos_byte = 8'h01;
            4'd3:    pos_byte = entry.speed[15:8];
            4'd4:    pos_byte = entry.speed[7:0];
            4'd5:    pos_byte = entry.accel;
            4'd6:    pos_byte = entry.steps[31:24];
            4'd7:    pos_byte = entry.steps[23:16];
            4'd8:    pos_byte = entry.steps[15:8];
            4'd9:    pos_byte = entry.steps[7:0];
            4'd10:   pos_byte = 8'h01;
            4'd11:   pos_byte = 8'h00;
            default: pos_byte = FRAME_END;
        endcase
    end

    always_comb
    begin
        unique case (ctl.kind)
            FR_SPEED:    frame_byte = speed_byte;
            FR_SYNC:     frame_byte = sync_byte;
            FR_POSITION: frame_byte = pos_byte;
            default:     frame_byte = sync_byte;
        endcase
    end

    assign byte_last = (ctl.index == frame_last_index(ctl.kind));

endmodule

>>> rtl/stepper_command_frame_scheduler.sv
// Stepper command frame scheduler: a five-entry target table lives in a
// synchronous memory, updated by set-speed and set-position commands and read
// on each tick to build the frame for the current slot, sent one byte per
// transaction. A set command reads the table entry, then writes it back. A
// tick reads the table entry, then sends its frame one byte at a time through
// the single output byte register; no frame is sent when the slot's motor is
// not pending. The block accepts the next item while the final byte still waits.
module stepper_command_frame_scheduler
    import scf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [2:0]         motor,
    input  logic signed [16:0] speed,
    input  logic [7:0]         accel,
    input  logic [31:0]        step_count,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         tx_byte,
    output logic               frame_last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Target table and its read port.
    entry_t               table_mem [0:MOTOR_COUNT-1];
    entry_t               rd_data_reg;
    logic                 rd_valid_reg;
    logic [MOTOR_COUNT-1:0] written_reg;
    logic [MOTOR_COUNT-1:0] pending_reg;

    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;

    // Latched command.
    logic [1:0]           cmd_op_reg;
    logic                 cmd_ok_reg;
    logic [MOTOR_W-1:0]   cmd_idx_reg;
    logic [SLOT_W-1:0]    cmd_slot_reg;
    logic signed [16:0]   cmd_speed_reg;
    logic [7:0]           cmd_accel_reg;
    logic [31:0]          cmd_steps_reg;

    frame_ctl_t           frame_reg;
    frame_ctl_t           frame_next;

    logic                 out_valid_reg;
    logic [7:0]           tx_byte_reg;
    logic                 frame_last_reg;

    logic                 in_accept;
    logic                 motor_ok;
    logic [MOTOR_W-1:0]   acc_idx;
    entry_t               entry_cur;
    entry_t               entry_new;
    logic                 wr_en;
    logic [16:0]          neg_mag;
    logic [15:0]          speed_mag;
    logic                 emit;
    logic                 out_load;
    logic [7:0]           fr_byte;
    logic                 fr_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign slot_next = (slot_reg == SLOT_MAX) ? '0 : slot_reg + 3'd1;
    assign motor_ok  = (motor >= 3'd1) && (32'(motor) <= MOTOR_COUNT);

    always_comb
    begin
        if (opcode == OP_TICK)
        begin
            acc_idx = (slot_next <= SLOT_LAST_SPEED) ? slot_next : POS_MOTOR_IDX;
        end
        else if (motor_ok)
        begin
            acc_idx = motor - 3'd1;
        end
        else
        begin
            acc_idx = '0;
        end
    end

    // An entry never written reads as its reset value of zero.
    assign entry_cur = rd_valid_reg ? rd_data_reg : '0;

    assign neg_mag   = 17'(-cmd_speed_reg);
    assign speed_mag = neg_mag[16] ? 16'hFFFF : neg_mag[15:0];

    always_comb
    begin
        entry_new = entry_cur;
        if (cmd_op_reg == OP_SPEED)
        begin
            entry_new.direction = cmd_speed_reg[16];
            entry_new.speed     = cmd_speed_reg[16] ? speed_mag : cmd_speed_reg[15:0];
        end
        else
        begin
            entry_new.speed = cmd_speed_reg[15:0];
            entry_new.accel = cmd_accel_reg;
            entry_new.steps = cmd_steps_reg;
        end
    end

    assign wr_en = (state_reg == ST_EXEC) && cmd_ok_reg &&
                   ((cmd_op_reg == OP_SPEED) || (cmd_op_reg == OP_POSITION));

    assign emit = (cmd_slot_reg == SLOT_SYNC) || pending_reg[cmd_idx_reg];

    assign out_load = (state_reg == ST_SEND) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        frame_next = frame_reg;
        if (state_reg == ST_EXEC)
        begin
            frame_next.index     = '0;
            frame_next.motor_idx = cmd_idx_reg;
            if (cmd_slot_reg <= SLOT_LAST_SPEED)
            begin
                frame_next.kind = FR_SPEED;
            end
            else if (cmd_slot_reg == SLOT_SYNC)
            begin
                frame_next.kind = FR_SYNC;
            end
            else
            begin
                frame_next.kind = FR_POSITION;
            end
        end
        else if (out_load)
        begin
            frame_next.index = frame_reg.index + 4'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((cmd_op_reg == OP_TICK) && emit)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (out_load && fr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    scf_framer u_framer (
        .ctl        (frame_reg),
        .entry      (entry_cur),
        .frame_byte (fr_byte),
        .byte_last  (fr_last)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[cmd_idx_reg] <= entry_new;
        end
        if (in_accept)
        begin
            rd_data_reg <= table_mem[acc_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            pending_reg    <= '1;
            written_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            cmd_op_reg     <= OP_TICK;
            cmd_ok_reg     <= 1'b0;
            cmd_idx_reg    <= '0;
            cmd_slot_reg   <= '0;
            frame_reg      <= '{kind: FR_SYNC, index: '0, motor_idx: '0};
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;

            if (in_accept)
            begin
                rd_valid_reg <= written_reg[acc_idx];
                cmd_op_reg   <= opcode;
                cmd_ok_reg   <= motor_ok;
                cmd_idx_reg  <= acc_idx;
                cmd_slot_reg <= slot_next;
                if (opcode == OP_TICK)
                begin
                    slot_reg <= slot_next;
                end
            end

            // The sync slot shares the position motor's table index but leaves
            // its pending mark alone.
            if (wr_en)
            begin
                written_reg[cmd_idx_reg] <= 1'b1;
                pending_reg[cmd_idx_reg] <= 1'b1;
            end
            else if ((state_reg == ST_EXEC) && (cmd_op_reg == OP_TICK) &&
                     (cmd_slot_reg != SLOT_SYNC) && emit)
            begin
                pending_reg[cmd_idx_reg] <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_speed_reg <= speed;
            cmd_accel_reg <= accel;
            cmd_steps_reg <= step_count;
        end
        if (out_load)
        begin
            tx_byte_reg    <= fr_byte;
            frame_last_reg <= fr_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign frame_last = frame_last_reg;

endmodule

>>> rtl/scf_checker.sv
module scf_checker
    import scf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] tx_byte,
    input logic       frame_last
);

    // Each accepted item holds the input side busy in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted on two consecutive cycles");

    // Every frame closes with the end byte.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (tx_byte == FRAME_END))
        else $error("frame_last on a byte other than the frame end");

    // While a frame is only partly sent, no new item may enter.
    a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_last) |-> in_stall)
        else $error("input accepted while a frame is still being sent");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(tx_byte) && $stable(frame_last)))
        else $error("stalled output transaction changed");

endmodule

bind stepper_command_frame_scheduler scf_checker u_scf_checker (.*);

>>> dv/stepper_command_frame_scheduler_tb.sv
module stepper_command_frame_scheduler_tb;
    import scf_pkg::*;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam int         RANDOM_PER_PHASE = 82;
    localparam int         HOLD_CYCLES      = 300;
    localparam int         DRAIN_CYCLES     = 40;
    localparam int         REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  mtr;
        logic [16:0] spd;
        logic [7:0]  acc;
        logic [31:0] stp;
    } command_t;

    // A typed_len of -1 means the frame comes from the scheduler model.
    typedef struct packed {
        command_t     cmd;
        int           typed_len;
        logic [103:0] typed;
    } script_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    typedef enum int {
        PH_FLAT,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_HOLD
    } flow_phase_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode     = OP_TICK;
    logic [2:0]         motor      = 3'd1;
    logic signed [16:0] speed      = '0;
    logic [7:0]         accel      = '0;
    logic [31:0]        step_count = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [7:0]         tx_byte;
    logic               frame_last;

    // Scheduler model state.
    logic [SLOT_W-1:0]  model_slot;
    logic               model_pending [MOTOR_COUNT];
    entry_t             motor_targets [MOTOR_COUNT];
    logic [7:0]         predicted_frame [$];

    tx_beat_t           expected_tx [$];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_pending   = 1'b0;
    int                 mismatches     = 0;
    int                 commands_sent  = 0;
    int                 bytes_checked  = 0;
    int                 frames_seen    = 0;

    stepper_command_frame_scheduler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .motor      (motor),
        .speed      (speed),
        .accel      (accel),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("stepper_command_frame_scheduler regression: fail");
        $finish;
    end

    function automatic void reset_model();
        model_slot = '0;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            model_pending[m] = 1'b1;
            motor_targets[m] = '0;
        end
    endfunction

    // Applies one command to the model and leaves the frame it sends, if any,
    // in predicted_frame.
    function automatic void predict_command(input command_t c);
        int          idx;
        logic [16:0] mag;
        predicted_frame.delete();
        if (c.op == OP_SPEED || c.op == OP_POSITION)
        begin
            if (c.mtr >= 1 && c.mtr <= MOTOR_COUNT)
            begin
                idx = c.mtr - 1;
                if (c.op == OP_SPEED)
                begin
                    if (c.spd[16])
                    begin
                        mag = -c.spd;
                        // Only -65536 has a magnitude beyond 16 bits.
                        if (mag[16])
                            mag = 17'h0FFFF;
                        motor_targets[idx].direction = 1'b1;
                        motor_targets[idx].speed     = mag[15:0];
                    end
                    else
                    begin
                        motor_targets[idx].direction = 1'b0;
                        motor_targets[idx].speed     = c.spd[15:0];
                    end
                end
                else
                begin
                    motor_targets[idx].speed = c.spd[15:0];
                    motor_targets[idx].accel = c.acc;
                    motor_targets[idx].steps = c.stp;
                end
                model_pending[idx] = 1'b1;
            end
        end
        else if (c.op == OP_TICK)
        begin
            model_slot = (model_slot == SLOT_MAX) ? '0 : model_slot + 1'b1;
            if (model_slot <= SLOT_LAST_SPEED)
            begin
                idx = model_slot;
                if (model_pending[idx])
                begin
                    model_pending[idx] = 1'b0;
                    predicted_frame = '{8'(idx + 1), CMD_SPEED,
                                        {7'd0, motor_targets[idx].direction},
                                        motor_targets[idx].speed[15:8],
                                        motor_targets[idx].speed[7:0],
                                        8'h00, 8'h01, FRAME_END};
                end
            end
            else if (model_slot == SLOT_SYNC)
            begin
                predicted_frame = '{BCAST_ADDR, SYNC_MARK, SYNC_CMD, FRAME_END};
            end
            else if (model_pending[POS_MOTOR_IDX])
            begin
                idx = POS_MOTOR_IDX;
                model_pending[idx] = 1'b0;
                // The position frame always carries direction 1.
                predicted_frame = '{8'(MOTOR_COUNT), CMD_POSITION, 8'h01,
                                    motor_targets[idx].speed[15:8],
                                    motor_targets[idx].speed[7:0],
                                    motor_targets[idx].accel,
                                    motor_targets[idx].steps[31:24],
                                    motor_targets[idx].steps[23:16],
                                    motor_targets[idx].steps[15:8],
                                    motor_targets[idx].steps[7:0],
                                    8'h01, 8'h00, FRAME_END};
            end
        end
    endfunction

    function automatic script_row_t mk_row(input logic [1:0] op, input logic [2:0] mtr,
                                           input logic [16:0] spd, input logic [7:0] acc,
                                           input logic [31:0] stp, input int typed_len = -1,
                                           input logic [103:0] typed = '0);
        script_row_t r;
        r.cmd       = '{op, mtr, spd, acc, stp};
        r.typed_len = typed_len;
        r.typed     = typed;
        return r;
    endfunction

    function automatic void set_flow(input flow_phase_t ph);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        case (ph)
            PH_SEND_IDLE:  send_idle_pct  = 71;
            PH_RECV_STALL: recv_stall_pct = 71;
            PH_BOTH:
            begin
                send_idle_pct  = 17;
                recv_stall_pct = 17;
            end
            PH_HOLD:       hold_pending   = 1'b1;
            default:       ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    // Offers one command, waits for the transaction, then records what it
    // should send and idles the input as the current phase asks.
    task automatic send_command(input command_t c, input int typed_len,
                                input logic [103:0] typed);
        int n;
        in_valid   <= 1'b1;
        opcode     <= c.op;
        motor      <= c.mtr;
        speed      <= c.spd;
        accel      <= c.acc;
        step_count <= c.stp;
        do
            @(posedge clk);
        while (in_stall);
        predict_command(c);
        if (typed_len < 0)
        begin
            n = predicted_frame.size();
            for (int i = 0; i < n; i++)
                expected_tx.push_back('{predicted_frame[i], i == n - 1});
        end
        else
        begin
            for (int i = 0; i < typed_len; i++)
                expected_tx.push_back('{typed[8*(typed_len-1-i) +: 8], i == typed_len - 1});
        end
        commands_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Output stall driver; a requested hold-off is counted out here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tx_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (frame_last)
                frames_seen++;
            if (expected_tx.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected byte %02h last %0b", tx_byte, frame_last));
            end
            else
            begin
                want = expected_tx.pop_front();
                if (want.data !== tx_byte || want.last !== frame_last)
                    flag_mismatch($sformatf("byte expected %02h last %0b, got %02h last %0b",
                                            want.data, want.last, tx_byte, frame_last));
            end
        end
    end

    initial
    begin
        script_row_t script [$];
        command_t    c;
        int          roll;
        flow_phase_t plan [5];

        plan = '{PH_FLAT, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD};
        reset_model();

        // Walk every slot from reset, then load extremes and bad commands.
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 8, 104'h02F600000000016B));
        script.push_back(mk_row(OP_TICK, 3'd7, '1, '1, '1, 8, 104'h03F600000000016B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 8, 104'h04F600000000016B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 4, 104'h00FF666B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 13,
                                104'h05FD010000000000000001006B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 8, 104'h01F600000000016B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 0));
        script.push_back(mk_row(OP_POSITION, 3'd1, 17'h01234, 8'd7, 32'h12345678));
        script.push_back(mk_row(OP_SPEED, 3'd1, 17'h10000, '0, '0));
        script.push_back(mk_row(OP_SPEED, 3'd2, 17'h0FFFF, '0, '0));
        script.push_back(mk_row(OP_SPEED, 3'd3, 17'h1FFFF, '0, '0));
        script.push_back(mk_row(OP_POSITION, 3'd3, 17'h10005, 8'd0, 32'd0));
        script.push_back(mk_row(OP_SPEED, 3'd4, 17'h00000, '1, '1));
        script.push_back(mk_row(OP_POSITION, 3'd5, 17'h1ABCD, 8'hFF, 32'hFFFFFFFF));
        script.push_back(mk_row(OP_SPEED, 3'd0, 17'h10000, '1, '1));
        script.push_back(mk_row(OP_POSITION, 3'd6, 17'h1FFFF, 8'hFF, 32'hFFFFFFFF));
        script.push_back(mk_row(OP_SPEED, 3'd7, 17'h0FFFF, '0, '0));
        script.push_back(mk_row(OP_UNUSED, 3'd5, 17'h1FFFF, 8'hFF, 32'hFFFFFFFF));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 4, 104'h00FF666B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 13,
                                104'h05FD01ABCDFFFFFFFFFF01006B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 8, 104'h01F601FFFF00016B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0, 8, 104'h02F600FFFF00016B));
        script.push_back(mk_row(OP_TICK, 3'd0, '0, '0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_flow(PH_FLAT);
        foreach (script[i])
            send_command(script[i].cmd, script[i].typed_len, script[i].typed);

        for (int p = 0; p < 5; p++)
        begin
            set_flow(plan[p]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                roll  = $urandom_range(99);
                c.mtr = 3'($urandom_range(1, MOTOR_COUNT));
                c.spd = 17'($urandom_range(0, 17'h1FFFF));
                c.acc = 8'($urandom_range(0, 255));
                c.stp = $urandom();
                if ($urandom_range(9) == 0)
                    c.spd = ($urandom_range(1) == 0) ? 17'h10000 : 17'h0FFFF;
                if (roll < 50)
                    c.op = OP_TICK;
                else if (roll < 70)
                    c.op = OP_SPEED;
                else if (roll < 90)
                    c.op = OP_POSITION;
                else if (roll < 95)
                begin
                    c.op  = ($urandom_range(1) == 0) ? OP_SPEED : OP_POSITION;
                    c.mtr = ($urandom_range(2) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
                end
                else
                    c.op = OP_UNUSED;
                send_command(c, -1, '0);
            end
        end

        in_valid <= 1'b0;
        set_flow(PH_FLAT);
        while (expected_tx.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d directed) and checked %0d bytes in %0d frames.",
                 commands_sent, script.size(), bytes_checked, frames_seen);
        $display("Flow control: free-running, sparse input, heavy and light stalls, %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && expected_tx.size() == 0)
        begin
            $display("stepper_command_frame_scheduler regression: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d bytes never seen", mismatches, expected_tx.size());
            $display("stepper_command_frame_scheduler regression: fail");
        end
        $finish;
    end

endmodule

>>> stepper_command_frame_scheduler.f
rtl/scf_pkg.sv
rtl/scf_framer.sv
rtl/stepper_command_frame_scheduler.sv
rtl/scf_checker.sv
dv/stepper_command_frame_scheduler_tb.sv
